### rtl/wtss_pkg.sv
// Shared types, widths and constants of the windowed trimmed sum smoother.
package wtss_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int POS_W      = 32;
    localparam int SCORE_W    = 16;
    localparam int SPAN_W     = 24;
    localparam int PROBE_W    = 7;
    localparam int TRIM_W     = 7;
    localparam int SMOOTH_W   = 23;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [SPAN_W-1:0]  SPAN_RST   = 24'd600;
    localparam logic [PROBE_W-1:0] PROBES_RST = 7'd10;
    localparam logic [TRIM_W-1:0]  TRIM_RST   = 7'd26;

    // saturation limits of the smoothed value
    localparam logic [31:0] SMOOTH_POS_MAX = 32'd4194303;
    localparam logic [31:0] SMOOTH_NEG_MAX = 32'd4194304;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPAN   = 2'd0,
        CFG_PROBES = 2'd1,
        CFG_TRIM   = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_CPOS_RD,
        OP_CPOS_CAP,
        OP_SCAN_ST,
        OP_DROP,
        OP_WRITE,
        OP_CP_RD,
        OP_CP_CAP,
        OP_SCAN_E,
        OP_DEC,
        OP_SCAN_S,
        OP_NCALC,
        OP_NCHK,
        OP_LO,
        OP_RANK_RD,
        OP_RANK_CAP,
        OP_RANK_J,
        OP_RANK_ACC,
        OP_MAG,
        OP_A2,
        OP_SQ,
        OP_CMP,
        OP_OUT,
        OP_FIN
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CPOS,
        ST_CPOS_W,
        ST_SCAN_ST,
        ST_DROP,
        ST_WRITE,
        ST_LOOP,
        ST_CP_W,
        ST_SCAN_E,
        ST_DEC,
        ST_SCAN_S,
        ST_NCALC,
        ST_NCHK,
        ST_LO,
        ST_RANK_I,
        ST_RANK_IW,
        ST_RANK_J,
        ST_RANK_ACC,
        ST_MAG,
        ST_A2,
        ST_SQ,
        ST_CMP,
        ST_OUT,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic pc_lt_fill;
        logic scan_done;
        logic e_lt_fill;
        logic last;
        logic full;
        logic pc_zero;
        logic n_ok;
        logic i_last;
        logic bit_zero;
        logic out_free;
    } t_stat;

endpackage

### rtl/wtss_ctrl.sv
// Sequencer of the smoother: steps the datapath through one input beat.
module wtss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  wtss_pkg::t_stat i_stat,
    output wtss_pkg::t_cmd  o_cmd
);

    wtss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = wtss_pkg::OP_NONE;
        o_cmd.take = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            wtss_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op   = wtss_pkg::OP_TAKE;
                    o_cmd.take = 1'b1;
                    n_state    = wtss_pkg::ST_CPOS;
                end
            end
            wtss_pkg::ST_CPOS: begin
                o_cmd.op = wtss_pkg::OP_CPOS_RD;
                n_state  = wtss_pkg::ST_CPOS_W;
            end
            wtss_pkg::ST_CPOS_W: begin
                o_cmd.op = wtss_pkg::OP_CPOS_CAP;
                n_state  = wtss_pkg::ST_SCAN_ST;
            end
            wtss_pkg::ST_SCAN_ST: begin
                o_cmd.op = wtss_pkg::OP_SCAN_ST;
                if (i_stat.scan_done) n_state = wtss_pkg::ST_DROP;
            end
            wtss_pkg::ST_DROP: begin
                o_cmd.op = wtss_pkg::OP_DROP;
                n_state  = wtss_pkg::ST_WRITE;
            end
            wtss_pkg::ST_WRITE: begin
                o_cmd.op = wtss_pkg::OP_WRITE;
                n_state  = wtss_pkg::ST_LOOP;
            end
            wtss_pkg::ST_LOOP: begin
                if (i_stat.pc_lt_fill) begin
                    o_cmd.op = wtss_pkg::OP_CP_RD;
                    n_state  = wtss_pkg::ST_CP_W;
                end else begin
                    n_state  = wtss_pkg::ST_FIN;
                end
            end
            wtss_pkg::ST_CP_W: begin
                o_cmd.op = wtss_pkg::OP_CP_CAP;
                n_state  = wtss_pkg::ST_SCAN_E;
            end
            wtss_pkg::ST_SCAN_E: begin
                o_cmd.op = wtss_pkg::OP_SCAN_E;
                if (i_stat.scan_done) n_state = wtss_pkg::ST_DEC;
            end
            wtss_pkg::ST_DEC: begin
                o_cmd.op = wtss_pkg::OP_DEC;
                if (i_stat.e_lt_fill || i_stat.last || (i_stat.full && i_stat.pc_zero)) begin
                    n_state = wtss_pkg::ST_SCAN_S;
                end else begin
                    n_state = wtss_pkg::ST_FIN;
                end
            end
            wtss_pkg::ST_SCAN_S: begin
                o_cmd.op = wtss_pkg::OP_SCAN_S;
                if (i_stat.scan_done) n_state = wtss_pkg::ST_NCALC;
            end
            wtss_pkg::ST_NCALC: begin
                o_cmd.op = wtss_pkg::OP_NCALC;
                n_state  = wtss_pkg::ST_NCHK;
            end
            wtss_pkg::ST_NCHK: begin
                o_cmd.op = wtss_pkg::OP_NCHK;
                n_state  = i_stat.n_ok ? wtss_pkg::ST_LO : wtss_pkg::ST_OUT;
            end
            wtss_pkg::ST_LO: begin
                o_cmd.op = wtss_pkg::OP_LO;
                n_state  = wtss_pkg::ST_RANK_I;
            end
            wtss_pkg::ST_RANK_I: begin
                o_cmd.op = wtss_pkg::OP_RANK_RD;
                n_state  = wtss_pkg::ST_RANK_IW;
            end
            wtss_pkg::ST_RANK_IW: begin
                o_cmd.op = wtss_pkg::OP_RANK_CAP;
                n_state  = wtss_pkg::ST_RANK_J;
            end
            wtss_pkg::ST_RANK_J: begin
                o_cmd.op = wtss_pkg::OP_RANK_J;
                if (i_stat.scan_done) n_state = wtss_pkg::ST_RANK_ACC;
            end
            wtss_pkg::ST_RANK_ACC: begin
                o_cmd.op = wtss_pkg::OP_RANK_ACC;
                n_state  = i_stat.i_last ? wtss_pkg::ST_MAG : wtss_pkg::ST_RANK_I;
            end
            wtss_pkg::ST_MAG: begin
                o_cmd.op = wtss_pkg::OP_MAG;
                n_state  = wtss_pkg::ST_A2;
            end
            wtss_pkg::ST_A2: begin
                o_cmd.op = wtss_pkg::OP_A2;
                n_state  = wtss_pkg::ST_SQ;
            end
            wtss_pkg::ST_SQ: begin
                o_cmd.op = wtss_pkg::OP_SQ;
                n_state  = wtss_pkg::ST_CMP;
            end
            wtss_pkg::ST_CMP: begin
                o_cmd.op = wtss_pkg::OP_CMP;
                n_state  = i_stat.bit_zero ? wtss_pkg::ST_OUT : wtss_pkg::ST_SQ;
            end
            wtss_pkg::ST_OUT: begin
                o_cmd.op = wtss_pkg::OP_OUT;
                if (i_stat.out_free) n_state = wtss_pkg::ST_LOOP;
            end
            wtss_pkg::ST_FIN: begin
                o_cmd.op = wtss_pkg::OP_FIN;
                n_state  = wtss_pkg::ST_IDLE;
            end
            default: begin
                n_state = wtss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/wtss_datapath.sv
// Datapath of the smoother: rings, scan engine, rank/trim sum, sqrt divide, output beat.
module wtss_datapath #(
    parameter int WINDOW_DEPTH = wtss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wtss_pkg::t_cmd                  i_cmd,
    output wtss_pkg::t_stat                 o_stat,
    input  logic [wtss_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wtss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wtss_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [wtss_pkg::OUT_USER_W-1:0] o_m_tuser,
    output logic                            o_m_tlast
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = wtss_pkg::SCORE_W + CW;
    localparam int TW = SW + 1;
    localparam int PW = 2 * TW + CW;
    localparam int BW = $clog2(SW);
    localparam int PSW = wtss_pkg::POS_W;
    localparam int SCW = wtss_pkg::SCORE_W;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] ws, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(ws) + (CW+1)'(off);
        if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
        return s[AW-1:0];
    endfunction

    // config
    logic [wtss_pkg::SPAN_W-1:0]  r_span;
    logic [wtss_pkg::PROBE_W-1:0] r_probes;
    logic [wtss_pkg::TRIM_W-1:0]  r_trim;

    // ring state
    logic [PSW-1:0]        pos_mem   [WINDOW_DEPTH];
    logic signed [SCW-1:0] score_mem [WINDOW_DEPTH];
    logic [PSW-1:0]        r_pos_q;
    logic signed [SCW-1:0] r_score_q;
    logic [AW-1:0]         r_ws;
    logic [CW-1:0]         r_pc, r_fill;
    logic                  r_ovf;

    // latched input beat
    logic [PSW-1:0]        r_in_pos;
    logic signed [SCW-1:0] r_in_score;
    logic                  r_in_last;

    // per-result work registers
    logic [PSW-1:0]        r_cpos;
    logic [CW-1:0]         r_st, r_e, r_st2, r_n, r_lo, r_i, r_rank;
    logic                  r_forced, r_ovf_res, r_res_ok;
    logic signed [SCW-1:0] r_vi;
    logic signed [SW-1:0]  r_sum;
    logic [SW-1:0]         r_mag, r_q;
    logic [2*SW-1:0]       r_a2;
    logic [2*TW-1:0]       r_sq;
    logic [BW-1:0]         r_bit;

    // scan engine
    logic [CW-1:0]         r_scan_k, r_rd_idx;
    logic                  r_rd_vld;

    // output beat
    logic                  r_out_valid, r_out_vres, r_out_ovf, r_out_last;
    logic [wtss_pkg::SMOOTH_W-1:0] r_out_smooth;

    logic [CW-1:0]   rd_off, scan_len, scan_res, kept, n_calc;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            is_scan, hit, scan_done, out_free, keep, rank_inc, out_load;
    logic [AW-1:0]   ws1, ws2;
    logic [CW-1:0]   fill1, fill2, pc1, pc2;
    logic            ovf2;
    logic [SW-1:0]   cand;
    logic [TW-1:0]   t_odd;
    logic [PW-1:0]   prod, rhs;
    logic [CW+wtss_pkg::TRIM_W-1:0] trim_prod;
    logic [31:0]     q32, qsat;
    logic [wtss_pkg::SMOOTH_W-1:0] smooth_val;

    // ---------------- scan addressing and compares ----------------
    always_comb begin
        is_scan  = 1'b0;
        scan_len = '0;
        hit      = 1'b0;
        rd_off   = r_scan_k;
        case (i_cmd.op)
            wtss_pkg::OP_CPOS_RD, wtss_pkg::OP_CP_RD: rd_off = r_pc;
            wtss_pkg::OP_RANK_RD: rd_off = r_st2 + r_i;
            wtss_pkg::OP_SCAN_ST: begin
                is_scan  = 1'b1;
                scan_len = r_pc;
                hit = ({1'b0, r_pos_q} + (PSW+1)'(r_span)) >= {1'b0, r_cpos};
            end
            wtss_pkg::OP_SCAN_S: begin
                is_scan  = 1'b1;
                scan_len = r_fill;
                hit = ({1'b0, r_pos_q} + (PSW+1)'(r_span)) >= {1'b0, r_cpos};
            end
            wtss_pkg::OP_SCAN_E: begin
                is_scan  = 1'b1;
                scan_len = r_fill;
                hit = {1'b0, r_pos_q} >= ({1'b0, r_cpos} + (PSW+1)'(r_span));
            end
            wtss_pkg::OP_RANK_J: begin
                is_scan  = 1'b1;
                scan_len = r_n;
                rd_off   = r_st2 + r_scan_k;
            end
            default: ;
        endcase
    end

    assign rd_addr   = f_slot(r_ws, rd_off);
    assign wr_addr   = f_slot(r_ws, r_fill);
    assign scan_done = is_scan && ((scan_len == '0) ||
                       (r_rd_vld && (hit || (r_rd_idx == scan_len - CW'(1)))));
    assign scan_res  = (r_rd_vld && hit) ? r_rd_idx : scan_len;
    assign rank_inc  = (r_score_q < r_vi) || ((r_score_q == r_vi) && (r_rd_idx < r_i));

    // ---------------- retention update ----------------
    always_comb begin
        ws1   = f_slot(r_ws, r_st);
        fill1 = r_fill - r_st;
        pc1   = r_pc - r_st;
        ws2   = ws1;
        fill2 = fill1;
        pc2   = pc1;
        ovf2  = (r_st != '0) ? 1'b0 : r_ovf;
        if (fill1 >= CW'(WINDOW_DEPTH)) begin
            ws2   = f_slot(ws1, CW'(1));
            fill2 = fill1 - CW'(1);
            pc2   = (pc1 != '0) ? pc1 - CW'(1) : pc1;
            ovf2  = 1'b1;
        end
    end

    // ---------------- window size, trim, sqrt divide ----------------
    assign n_calc    = ((r_e >= r_st2) && (r_e < r_fill)) ? (r_e - r_st2 + CW'(1)) : '0;
    assign trim_prod = (CW+wtss_pkg::TRIM_W)'(r_n) * (CW+wtss_pkg::TRIM_W)'(r_trim);
    assign kept      = r_n - {r_lo[CW-2:0], 1'b0};
    assign keep      = (r_rank >= r_lo) && ((CW+1)'(r_rank) < ((CW+1)'(r_lo) + (CW+1)'(kept)));
    assign cand      = r_q | (SW'(1) << r_bit);
    assign t_odd     = {cand, 1'b0} - TW'(1);
    assign prod      = PW'(r_sq) * PW'(kept);
    assign rhs       = PW'(r_a2) << 2;

    always_comb begin
        q32  = 32'(r_q);
        qsat = q32;
        if (r_sum < 0) begin
            if (q32 > wtss_pkg::SMOOTH_NEG_MAX) qsat = wtss_pkg::SMOOTH_NEG_MAX;
            smooth_val = wtss_pkg::SMOOTH_W'(32'd0 - qsat);
        end else begin
            if (q32 > wtss_pkg::SMOOTH_POS_MAX) qsat = wtss_pkg::SMOOTH_POS_MAX;
            smooth_val = wtss_pkg::SMOOTH_W'(qsat);
        end
        if (!r_res_ok) smooth_val = '0;
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign out_load = (i_cmd.op == wtss_pkg::OP_OUT) && out_free;

    // ---------------- ring memories ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == wtss_pkg::OP_WRITE) begin
            pos_mem[wr_addr]   <= r_in_pos;
            score_mem[wr_addr] <= r_in_score;
        end
        r_pos_q   <= pos_mem[rd_addr];
        r_score_q <= score_mem[rd_addr];
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span      <= wtss_pkg::SPAN_RST;
            r_probes    <= wtss_pkg::PROBES_RST;
            r_trim      <= wtss_pkg::TRIM_RST;
            r_ws        <= '0;
            r_pc        <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_scan_k    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (wtss_pkg::t_cfg_idx'(i_cfg_index))
                    wtss_pkg::CFG_SPAN:   r_span   <= i_cfg_data;
                    wtss_pkg::CFG_PROBES: r_probes <= i_cfg_data[wtss_pkg::PROBE_W-1:0];
                    wtss_pkg::CFG_TRIM:   r_trim   <= i_cfg_data[wtss_pkg::TRIM_W-1:0];
                    default: ;
                endcase
            end

            if (is_scan) begin
                if (r_scan_k < scan_len) begin
                    r_scan_k <= r_scan_k + CW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end else begin
                r_scan_k <= '0;
                r_rd_vld <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (i_cmd.op)
                wtss_pkg::OP_DROP: begin
                    r_ws   <= ws2;
                    r_fill <= fill2;
                    r_pc   <= pc2;
                    r_ovf  <= ovf2;
                end
                wtss_pkg::OP_WRITE: r_fill <= r_fill + CW'(1);
                wtss_pkg::OP_OUT: begin
                    if (out_free) begin
                        r_pc <= r_pc + CW'(1);
                    end
                end
                wtss_pkg::OP_FIN: begin
                    if (r_in_last) begin
                        r_ws   <= '0;
                        r_pc   <= '0;
                        r_fill <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (is_scan && (r_scan_k < scan_len)) r_rd_idx <= r_scan_k;
        case (i_cmd.op)
            wtss_pkg::OP_TAKE: begin
                if (i_cmd.take) begin
                    r_in_pos   <= i_s_tdata[PSW-1:0];
                    r_in_score <= i_s_tdata[PSW+SCW-1:PSW];
                    r_in_last  <= i_s_tlast;
                end
            end
            wtss_pkg::OP_CPOS_CAP: r_cpos <= (r_pc < r_fill) ? r_pos_q : r_in_pos;
            wtss_pkg::OP_CP_CAP:   r_cpos <= r_pos_q;
            wtss_pkg::OP_SCAN_ST:  if (scan_done) r_st  <= scan_res;
            wtss_pkg::OP_SCAN_E:   if (scan_done) r_e   <= scan_res;
            wtss_pkg::OP_SCAN_S:   if (scan_done) r_st2 <= scan_res;
            wtss_pkg::OP_DEC: begin
                if (r_e >= r_fill) r_e <= r_fill - CW'(1);
                r_forced <= (r_e >= r_fill) && !r_in_last;
            end
            wtss_pkg::OP_NCALC: begin
                r_n       <= n_calc;
                r_ovf_res <= r_forced || (r_ovf && (r_st2 == '0));
            end
            wtss_pkg::OP_NCHK: begin
                r_res_ok <= o_stat.n_ok;
                r_sum    <= '0;
            end
            wtss_pkg::OP_LO: begin
                r_lo  <= CW'(trim_prod >> 8);
                r_i   <= '0;
                r_sum <= '0;
            end
            wtss_pkg::OP_RANK_CAP: begin
                r_vi   <= r_score_q;
                r_rank <= '0;
            end
            wtss_pkg::OP_RANK_J: if (r_rd_vld && rank_inc) r_rank <= r_rank + CW'(1);
            wtss_pkg::OP_RANK_ACC: begin
                if (keep) r_sum <= r_sum + SW'(r_vi);
                r_i <= r_i + CW'(1);
            end
            wtss_pkg::OP_MAG: r_mag <= (r_sum < 0) ? SW'(-r_sum) : SW'(r_sum);
            wtss_pkg::OP_A2: begin
                r_a2  <= (2*SW)'(r_mag) * (2*SW)'(r_mag);
                r_q   <= '0;
                r_bit <= BW'(SW - 1);
            end
            wtss_pkg::OP_SQ: r_sq <= (2*TW)'(t_odd) * (2*TW)'(t_odd);
            wtss_pkg::OP_CMP: begin
                if (prod <= rhs) r_q <= cand;
                r_bit <= r_bit - BW'(1);
            end
            wtss_pkg::OP_OUT: begin
                if (out_free) begin
                    r_out_smooth <= smooth_val;
                    r_out_vres   <= r_res_ok;
                    r_out_ovf    <= r_ovf_res;
                    r_out_last   <= r_in_last && ((CW+1)'(r_pc) + (CW+1)'(1) == (CW+1)'(r_fill));
                end
            end
            default: ;
        endcase
    end

    // ---------------- status and ports ----------------
    always_comb begin
        o_stat.pc_lt_fill = r_pc < r_fill;
        o_stat.scan_done  = scan_done;
        o_stat.e_lt_fill  = r_e < r_fill;
        o_stat.last       = r_in_last;
        o_stat.full       = r_fill >= CW'(WINDOW_DEPTH);
        o_stat.pc_zero    = r_pc == '0;
        o_stat.n_ok       = (r_n != '0) && (16'(r_n) >= 16'(r_probes));
        o_stat.i_last     = ((CW+1)'(r_i) + (CW+1)'(1)) == (CW+1)'(r_n);
        o_stat.bit_zero   = r_bit == '0;
        o_stat.out_free   = out_free;
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_out_smooth};
    assign o_m_tuser   = {r_out_ovf, r_out_vres};
    assign o_m_tlast   = r_out_last;

endmodule

### rtl/windowed_trimmed_sum_smoother_core.sv
// Top level of the windowed trimmed sum smoother: sequencer plus datapath.
//
//  channel   dir  handshake                  payload
//  ------    ---  ---------                  -------
//  s (item)  in   i_s_tvalid / o_s_tready    i_s_tdata, i_s_tlast (is_last)
//  m (res)   out  o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser, o_m_tlast (last_result)
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input beat at a time. Per beat: take it, scan for the window start, release/drop
// and write the rings. Then per result: scans for the window end and start, rank counting
// over the n window entries through the single ring read port, and the bit-serial sqrt
// divide; after the last result the beat is finished.
// Reset (synchronous, active low) empties the rings logically; no clearing pass is run.
// A stalled result beat holds in the output register; the sequencer waits on it only
// when the next result is ready. Config is taken in any cycle.
module windowed_trimmed_sum_smoother_core #(
    parameter int WINDOW_DEPTH = wtss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item beat
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wtss_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [31:0] position, [47:32] score
    input  logic                            i_s_tlast,
    // result beat
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wtss_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [22:0] smoothed, [23] zero
    output logic [wtss_pkg::OUT_USER_W-1:0] o_m_tuser,   // [0] valid_res, [1] overflow
    output logic                            o_m_tlast,
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wtss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wtss_pkg::t_cmd  cmd;
    wtss_pkg::t_stat stat;

    // sequencer: one state per datapath step
    wtss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // rings, scans, trim sum, sqrt divide and output register
    wtss_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### rtl/wtss_checker.sv
// Port-level checks of the smoother core, bound to the top level.
module wtss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [wtss_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [wtss_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [wtss_pkg::OUT_USER_W-1:0] o_m_tuser,
    input logic                            o_m_tlast,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [wtss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [wtss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // after reset: empty output, ready for an item
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("state after reset wrong");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result beat changed while stalled");

    // invalid result carries zero value
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("invalid result with nonzero value");

    // one item at a time: ready drops after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted while busy");

endmodule

bind windowed_trimmed_sum_smoother_core wtss_checker u_wtss_checker (.*);

### tb/tb_windowed_trimmed_sum_smoother_checker.sv
// Result checker for the windowed trimmed sum smoother: predicts every result beat and compares.
module tb_windowed_trimmed_sum_smoother_checker
    import wtss_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        logic [SMOOTH_W-1:0] smoothed;
        logic                valid_res;
        logic                overflow;
        logic                last_result;
    } t_smooth_res;

    t_smooth_res smooth_q[$];

    // mirrored configuration
    logic [SPAN_W-1:0]  span;
    logic [PROBE_W-1:0] probes;
    logic [TRIM_W-1:0]  trim;

    // mirrored window state
    logic [POS_W-1:0]   ring_pos   [DEPTH];
    logic [SCORE_W-1:0] ring_score [DEPTH];
    int unsigned        win_start;
    int unsigned        center;
    int unsigned        fill;
    logic               ovf_flag;

    int errors;

    assign o_pending = smooth_q.size();
    assign o_errors  = errors;

    function automatic int unsigned ring_slot(int unsigned off);
        return (win_start + off) % DEPTH;
    endfunction

    function automatic longint ring_at(int unsigned off);
        return longint'(ring_pos[ring_slot(off)]);
    endfunction

    function automatic int unsigned first_not_below(longint bound);
        for (int unsigned j = 0; j < fill; j++)
            if (ring_at(j) >= bound) return j;
        return fill;
    endfunction

    // round(a / sqrt(k)), ties up
    function automatic longint unsigned div_by_root(longint unsigned a, longint unsigned k);
        longint unsigned lo, hi, mid, t, rhs;
        lo  = 0;
        hi  = 64'd1 << 23;
        rhs = 4 * a * a;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t   = 2 * mid - 1;
            if (t * t * k <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // trimmed smoothed value of the window of centre c ending at offset e
    function automatic t_smooth_res window_result(int unsigned c, int unsigned e, bit forced);
        t_smooth_res r;
        int          vals [DEPTH];
        int unsigned st, n, lo, kept, j;
        int          v;
        longint      sum;
        longint unsigned mag, q;
        st = first_not_below(ring_at(c) - longint'(span));
        n  = (e >= st && e < fill) ? e - st + 1 : 0;
        r  = '0;
        r.overflow = forced || (ovf_flag && st == 0);
        if (n == 0 || n < probes) return r;
        for (int unsigned i = 0; i < n; i++) begin
            v = $signed(ring_score[ring_slot(st + i)]);
            j = i;
            while (j > 0 && vals[j-1] > v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        lo   = (n * trim) >> 8;
        kept = n - 2 * lo;
        sum  = 0;
        for (int unsigned i = lo; i < lo + kept; i++) sum += vals[i];
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        q   = div_by_root(mag, kept);
        if (sum < 0) begin
            if (q > SMOOTH_NEG_MAX) q = SMOOTH_NEG_MAX;
            r.smoothed = SMOOTH_W'(-q);
        end else begin
            if (q > SMOOTH_POS_MAX) q = SMOOTH_POS_MAX;
            r.smoothed = SMOOTH_W'(q);
        end
        r.valid_res = 1'b1;
        return r;
    endfunction

    // take one item beat, queue the results it closes
    task automatic absorb_item(logic [POS_W-1:0] pos, logic [SCORE_W-1:0] score, logic last);
        longint      cpos;
        int unsigned st, e;
        int          made;
        t_smooth_res r;
        made = 0;
        cpos = (center < fill) ? ring_at(center) : longint'(pos);
        st   = first_not_below(cpos - longint'(span));
        if (st > center) st = center;
        if (st > 0) begin
            win_start = ring_slot(st);
            fill     -= st;
            center   -= st;
            ovf_flag  = 1'b0;
        end
        if (fill >= DEPTH) begin
            win_start = ring_slot(1);
            fill--;
            if (center > 0) center--;
            ovf_flag = 1'b1;
        end
        ring_pos[ring_slot(fill)]   = pos;
        ring_score[ring_slot(fill)] = score;
        fill++;
        while (center < fill) begin
            e = first_not_below(ring_at(center) + longint'(span));
            if (e < fill) r = window_result(center, e, 1'b0);
            else if (last) r = window_result(center, fill - 1, 1'b0);
            else if (fill >= DEPTH && center == 0) r = window_result(center, fill - 1, 1'b1);
            else break;
            smooth_q.push_back(r);
            made++;
            center++;
        end
        if (last) begin
            if (made > 0) smooth_q[$].last_result = 1'b1;
            win_start = 0;
            center    = 0;
            fill      = 0;
            ovf_flag  = 1'b0;
        end
    endtask

    task automatic report(string what);
        $display("checker: mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_smooth_res want;
        if (!i_rst_n) begin
            span      = SPAN_RST;
            probes    = PROBES_RST;
            trim      = TRIM_RST;
            win_start = 0;
            center    = 0;
            fill      = 0;
            ovf_flag  = 1'b0;
            smooth_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (smooth_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = smooth_q.pop_front();
                    if (i_m_tdata[SMOOTH_W-1:0] != want.smoothed)
                        report($sformatf("smoothed %h, want %h",
                                         i_m_tdata[SMOOTH_W-1:0], want.smoothed));
                    if (i_m_tuser[0] != want.valid_res)
                        report($sformatf("valid_res %b, want %b", i_m_tuser[0], want.valid_res));
                    if (i_m_tuser[1] != want.overflow)
                        report($sformatf("overflow %b, want %b", i_m_tuser[1], want.overflow));
                    if (i_m_tlast != want.last_result)
                        report($sformatf("last %b, want %b", i_m_tlast, want.last_result));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPAN:   span   = i_cfg_data[SPAN_W-1:0];
                    CFG_PROBES: probes = i_cfg_data[PROBE_W-1:0];
                    CFG_TRIM:   trim   = i_cfg_data[TRIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                absorb_item(i_s_tdata[POS_W-1:0], i_s_tdata[POS_W +: SCORE_W], i_s_tlast);
        end
    end

endmodule

### tb/tb_windowed_trimmed_sum_smoother_core.sv
// Stimulus and verdict for the windowed trimmed sum smoother core.
module tb_windowed_trimmed_sum_smoother_core;
    import wtss_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int  pending;
    int  errors;
    int  items_sent;
    bit  calm;          // no idling on either side while set

    windowed_trimmed_sum_smoother_core dut (.*);

    tb_windowed_trimmed_sum_smoother_checker chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tlast,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(posedge i_clk)
        i_m_tready <= calm || ($urandom_range(99) >= 29);

    task automatic send_item(logic [POS_W-1:0] pos, logic [SCORE_W-1:0] score, logic last);
        if (!calm && $urandom_range(99) < 29) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {score, pos};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // wait out every expected beat, then let the sequencer settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [SPAN_W-1:0] span, logic [PROBE_W-1:0] probes,
                            logic [TRIM_W-1:0] trim);
        t_cfg_idx idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{CFG_SPAN, CFG_PROBES, CFG_TRIM};
        val = '{span, CFG_DATA_W'(probes), CFG_DATA_W'(trim)};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one stream closed by is_last; rough marks some positions out of order
    task automatic run_stream(int len, int step_max, bit rough);
        logic [POS_W-1:0] pos;
        pos = $urandom;
        for (int k = 0; k < len; k++) begin
            if (rough && $urandom_range(9) == 0) pos = pos - $urandom_range(3000);
            else pos = pos + $urandom_range(step_max);
            send_item(pos, SCORE_W'($urandom), k == len - 1);
        end
    endtask

    initial begin
        int phase;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SPAN;
        i_cfg_data  = '0;
        calm        = 1'b0;
        items_sent  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, lone item, top position
        send_item(32'd0, 16'h7FFF, 1'b1);
        for (int k = 0; k < 12; k++)
            send_item(32'(k * 50), (k % 2) ? 16'h8000 : 16'h7FFF, 1'b0);
        send_item(32'd10, 16'h0000, 1'b0);         // out of order
        send_item(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        drain();

        // whole stream in one window: ring fills, forced close and overflow
        set_regs(24'hFF_FFFF, 7'd1, 7'd0);
        for (int k = 0; k < 75; k++)
            send_item(32'(1000 + k), (k % 3) ? 16'h7FFF : 16'h8000, k == 74);
        drain();

        // zero span, zero probes, heaviest trim
        set_regs(24'd0, 7'd0, 7'd127);
        run_stream(10, 2, 1'b1);
        drain();

        set_regs(24'd1000, 7'd64, 7'd125);
        calm = 1'b1;
        run_stream(70, 10, 1'b0);
        drain();
        calm = 1'b0;

        set_regs(24'd300, 7'd127, 7'd26);
        run_stream(8, 100, 1'b0);
        drain();

        // random part, mostly well-formed streams with random content
        phase = 0;
        while (items_sent < 220) begin
            calm = (phase == 3);
            set_regs(24'($urandom_range(2000)), 7'($urandom_range(12, 1)),
                     7'($urandom_range(125)));
            repeat ($urandom_range(3, 1))
                run_stream($urandom_range(30, 1), $urandom_range(400, 1),
                           $urandom_range(3) == 0);
            drain();
            phase++;
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
